// ===== rtl/bsbp_pkg.sv =====
package bsbp_pkg;

    // Sequencer states of the plotter core.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_FIN
    } state_t;

    // Request kinds carried on the input tuser bit.
    localparam logic REQ_PLOT = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Leftmost pixel of a byte sits in the most significant bit.
    localparam logic [7:0] PIX_MSB_MASK = 8'h80;

    localparam int BRUSH_W  = 3;
    localparam int COUNT_W  = 5;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;

endpackage

// ===== rtl/bsbp_ram.sv =====
module bsbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/brush_stamp_bitplane_plotter_core.sv =====
// A read word goes through RD_ADDR and RD_DATA to FIN, where its result is loaded for output.
// A plot word visits each brush offset in turn: an on-picture pixel takes a read and a write
// state, a clipped pixel only the read state; one shared read-modify-write path does each pixel,
// and the next word is taken in the cycle after the result is loaded.
// The input is accepted again as soon as the core is idle, even while a result waits.
// After aresetn the core clears all PLANE_BYTES byte pairs (2048 by default), one byte pair a
// cycle, and takes no input word meanwhile; brush_size resets to 1.
module brush_stamp_bitplane_plotter_core #(
    parameter int PLANE_BYTES = 2048,
    parameter int ROW_BYTES   = 32,
    parameter int MAX_BRUSH   = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration: brush_size.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bsbp_pkg::BRUSH_W-1:0]     cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cursor_x[7:0], cursor_y[13:8], pixel_color[15:14], read_addr[26:16], zero fill.
    input  logic [bsbp_pkg::S_DATA_W-1:0]    s_tdata,
    // req_type[0].
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // plane0_byte[7:0], plane1_byte[15:8], pixels_written[20:16], zero fill.
    output logic [bsbp_pkg::M_DATA_W-1:0]    m_tdata
);

    localparam int AW    = $clog2(PLANE_BYTES);
    localparam int PIC_W = ROW_BYTES * 8;
    localparam int PIC_H = PLANE_BYTES / ROW_BYTES;

    bsbp_pkg::state_t state_reg, state_next;

    logic [bsbp_pkg::BRUSH_W-1:0] brush_size_reg;
    logic [AW-1:0]                clr_addr_reg, clr_addr_next;
    logic                         req_reg;
    logic [7:0]                   cx_reg;
    logic [5:0]                   cy_reg;
    logic [1:0]                   color_reg;
    logic [10:0]                  raddr_reg;
    logic [1:0]                   last_reg;
    logic                         lo_sub_reg;
    logic [1:0]                   dx_reg, dx_next;
    logic [1:0]                   dy_reg, dy_next;
    logic [AW-1:0]                waddr_reg, waddr_next;
    logic [7:0]                   mask_reg, mask_next;
    logic [bsbp_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]                   res_p0_reg, res_p0_next;
    logic [7:0]                   res_p1_reg, res_p1_next;
    logic                         m_tvalid_reg;
    logic [bsbp_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic                         accept;
    logic                         load_out;
    logic                         brush_ok;
    logic signed [9:0]            px_s;
    logic signed [7:0]            py_s;
    logic                         pix_in;
    logic [AW-1:0]                pix_addr;
    logic                         raddr_ok;
    logic                         last_pix;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [15:0]                  ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [15:0]                  ram_rdata;

    bsbp_ram #(
        .WIDTH (16),
        .DEPTH (PLANE_BYTES)
    ) u_planes (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == bsbp_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Brush sizes outside 2..4 (or above MAX_BRUSH) stamp one pixel.
    assign brush_ok = (brush_size_reg >= 3'd2) && (brush_size_reg <= 3'd4)
                      && (32'(brush_size_reg) <= MAX_BRUSH);

    // Pixel under the current brush offset; sizes 3 and 4 start one left and up.
    assign px_s = $signed({2'b00, cx_reg}) + $signed({8'b0, dx_reg})
                  - $signed({9'b0, lo_sub_reg});
    assign py_s = $signed({2'b00, cy_reg}) + $signed({6'b0, dy_reg})
                  - $signed({7'b0, lo_sub_reg});
    assign pix_in = (px_s >= 0) && (px_s < PIC_W) && (py_s >= 0) && (py_s < PIC_H);
    assign pix_addr = AW'(py_s[6:0]) * AW'(ROW_BYTES) + AW'(px_s[8:3]);
    assign last_pix = (dx_reg == last_reg) && (dy_reg == last_reg);
    assign raddr_ok = 32'(raddr_reg) < PLANE_BYTES;

    assign load_out = (state_reg == bsbp_pkg::ST_FIN) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        waddr_next    = waddr_reg;
        mask_next     = mask_reg;
        count_next    = count_reg;
        res_p0_next   = res_p0_reg;
        res_p1_next   = res_p1_reg;
        ram_we        = 1'b0;
        ram_waddr     = waddr_reg;
        ram_wdata     = '0;
        ram_raddr     = pix_addr;

        unique case (state_reg)
            bsbp_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                if (clr_addr_reg == AW'(PLANE_BYTES - 1)) begin
                    state_next = bsbp_pkg::ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            bsbp_pkg::ST_IDLE: begin
                if (accept) begin
                    dx_next     = '0;
                    dy_next     = '0;
                    count_next  = '0;
                    res_p0_next = '0;
                    res_p1_next = '0;
                    state_next  = (s_tuser == bsbp_pkg::REQ_READ) ? bsbp_pkg::ST_RD_ADDR
                                                                   : bsbp_pkg::ST_PIX_RD;
                end
            end
            bsbp_pkg::ST_PIX_RD: begin
                waddr_next = pix_addr;
                mask_next  = bsbp_pkg::PIX_MSB_MASK >> px_s[2:0];
                if (pix_in) begin
                    state_next = bsbp_pkg::ST_PIX_WR;
                end else begin
                    // Clipped pixel: step to the next offset without touching memory.
                    if (dx_reg == last_reg) begin
                        dx_next = '0;
                        dy_next = dy_reg + 1'b1;
                    end else begin
                        dx_next = dx_reg + 1'b1;
                    end
                    if (last_pix) begin
                        state_next = bsbp_pkg::ST_FIN;
                    end
                end
            end
            bsbp_pkg::ST_PIX_WR: begin
                ram_we     = 1'b1;
                ram_wdata  = (ram_rdata & ~{mask_reg, mask_reg})
                             | ({{8{color_reg[1]}}, {8{color_reg[0]}}} & {mask_reg, mask_reg});
                count_next = count_reg + 1'b1;
                if (dx_reg == last_reg) begin
                    dx_next = '0;
                    dy_next = dy_reg + 1'b1;
                end else begin
                    dx_next = dx_reg + 1'b1;
                end
                state_next = last_pix ? bsbp_pkg::ST_FIN : bsbp_pkg::ST_PIX_RD;
            end
            bsbp_pkg::ST_RD_ADDR: begin
                ram_raddr  = AW'(raddr_reg);
                state_next = bsbp_pkg::ST_RD_DATA;
            end
            bsbp_pkg::ST_RD_DATA: begin
                if (raddr_ok) begin
                    res_p0_next = ram_rdata[7:0];
                    res_p1_next = ram_rdata[15:8];
                end
                state_next = bsbp_pkg::ST_FIN;
            end
            bsbp_pkg::ST_FIN: begin
                if (load_out) begin
                    state_next = bsbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bsbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bsbp_pkg::ST_CLEAR;
            clr_addr_reg   <= '0;
            brush_size_reg <= 3'd1;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            if (cfg_valid && cfg_ready) begin
                brush_size_reg <= cfg_data;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        waddr_reg  <= waddr_next;
        mask_reg   <= mask_next;
        count_reg  <= count_next;
        res_p0_reg <= res_p0_next;
        res_p1_reg <= res_p1_next;
        if (accept) begin
            req_reg    <= s_tuser;
            cx_reg     <= s_tdata[7:0];
            cy_reg     <= s_tdata[13:8];
            color_reg  <= s_tdata[15:14];
            raddr_reg  <= s_tdata[26:16];
            last_reg   <= brush_ok ? 2'(brush_size_reg - 3'd1) : 2'd0;
            lo_sub_reg <= brush_ok && (brush_size_reg >= 3'd3);
        end
        if (load_out) begin
            m_tdata_reg <= {3'b000, count_reg, res_p1_reg, res_p0_reg};
        end
    end

    // Memory is written only by the clearing pass or a pixel update.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == bsbp_pkg::ST_CLEAR || state_reg == bsbp_pkg::ST_PIX_WR))
        else $error("framebuffer written outside clear or pixel update");

    // A pixel write always follows the read of the same byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bsbp_pkg::ST_PIX_WR) |-> $past(state_reg) == bsbp_pkg::ST_PIX_RD)
        else $error("pixel write without preceding read");

    // Read results never report stamped pixels.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bsbp_pkg::ST_FIN && req_reg == bsbp_pkg::REQ_READ) |-> count_reg == '0)
        else $error("nonzero pixel count on a read result");

    // A brush never stamps more than sixteen pixels.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bsbp_pkg::ST_FIN) |-> count_reg <= 5'd16)
        else $error("pixel count above brush area");

    // No input word is taken until the clearing pass is over.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bsbp_pkg::ST_CLEAR) |=> !$past(accept))
        else $error("input accepted during clearing pass");

endmodule

// ===== tb/brush_stamp_bitplane_plotter_core_tb.sv =====
module brush_stamp_bitplane_plotter_core_tb;

    localparam int PLANE_BYTES = 2048;
    localparam int ROW_BYTES   = 32;
    localparam int PIC_W       = ROW_BYTES * 8;
    localparam int PIC_H       = PLANE_BYTES / ROW_BYTES;
    localparam int PHASE_ITEMS = 235;
    localparam int DRAIN_WAIT  = 40;

    // Shadow framebuffer plus the queue of plane bytes and pixel counts still owed.
    class plane_scoreboard;
        typedef struct {
            logic [7:0]                   p0;
            logic [7:0]                   p1;
            logic [bsbp_pkg::COUNT_W-1:0] count;
        } plot_result_t;

        bit [7:0]                   plane_lo [PLANE_BYTES];
        bit [7:0]                   plane_hi [PLANE_BYTES];
        bit [bsbp_pkg::BRUSH_W-1:0] brush = 3'd1;
        plot_result_t               owed [$];
        int                         errors = 0;
        int                         n_reads = 0;
        int                         n_plots = 0;
        int                         n_stamped = 0;

        function void set_brush(logic [bsbp_pkg::BRUSH_W-1:0] v);
            brush = v;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void note_request(logic req, logic [bsbp_pkg::S_DATA_W-1:0] word);
            plot_result_t r;
            int           x, y, px, py, n, lo, hi, addr;
            logic [1:0]   color;
            logic [7:0]   mask;
            x     = word[7:0];
            y     = word[13:8];
            color = word[15:14];
            addr  = word[26:16];
            r.p0 = 8'd0;
            r.p1 = 8'd0;
            r.count = '0;
            if (req == bsbp_pkg::REQ_READ) begin
                if (addr < PLANE_BYTES) begin
                    r.p0 = plane_lo[addr];
                    r.p1 = plane_hi[addr];
                end
                n_reads++;
            end else begin
                n = brush;
                if (n < 2 || n > 4) begin
                    n = 1;
                end
                lo = -((n - 1) / 2);
                hi = n / 2;
                for (int dy = lo; dy <= hi; dy++) begin
                    for (int dx = lo; dx <= hi; dx++) begin
                        px = x + dx;
                        py = y + dy;
                        // Pixels off the picture are dropped, never wrapped.
                        if (px >= 0 && py >= 0 && px < PIC_W && py < PIC_H) begin
                            addr = py * ROW_BYTES + px / 8;
                            mask = bsbp_pkg::PIX_MSB_MASK >> (px % 8);
                            plane_lo[addr] = (plane_lo[addr] & ~mask) | (color[0] ? mask : 8'd0);
                            plane_hi[addr] = (plane_hi[addr] & ~mask) | (color[1] ? mask : 8'd0);
                            r.count++;
                        end
                    end
                end
                n_plots++;
                n_stamped += r.count;
            end
            owed.push_back(r);
        endfunction

        function void check_result(logic [bsbp_pkg::M_DATA_W-1:0] word);
            plot_result_t want;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: result word %h arrived with nothing outstanding", $time, word);
                return;
            end
            want = owed.pop_front();
            if (word[7:0] !== want.p0) begin
                errors++;
                $display("%0t: plane0_byte expected %h, got %h", $time, want.p0, word[7:0]);
            end
            if (word[15:8] !== want.p1) begin
                errors++;
                $display("%0t: plane1_byte expected %h, got %h", $time, want.p1, word[15:8]);
            end
            if (word[20:16] !== want.count) begin
                errors++;
                $display("%0t: pixels_written expected %0d, got %0d", $time, want.count,
                         word[20:16]);
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [bsbp_pkg::BRUSH_W-1:0]    cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [bsbp_pkg::S_DATA_W-1:0]   s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [bsbp_pkg::M_DATA_W-1:0]   m_tdata;

    plane_scoreboard sb;
    int              send_gap_pct;
    int              stall_pct;
    int              last_x;
    int              last_y;
    logic [2:0]      brush_plan [8] = '{3'd4, 3'd0, 3'd2, 3'd3, 3'd7, 3'd1, 3'd5, 3'd6};

    brush_stamp_bitplane_plotter_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Every word and register write is recorded where the handshake completes.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.set_brush(cfg_data);
            end
            if (s_tvalid && s_tready) begin
                sb.note_request(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [bsbp_pkg::S_DATA_W-1:0] pack_word(int x, int y, int color,
                                                                int addr);
        pack_word = '0;
        pack_word[7:0]   = x[7:0];
        pack_word[13:8]  = y[5:0];
        pack_word[15:14] = color[1:0];
        pack_word[26:16] = addr[10:0];
        return pack_word;
    endfunction

    task automatic send_word(input logic req, input logic [bsbp_pkg::S_DATA_W-1:0] word);
        @(negedge aclk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic plot(input int x, input int y, input int color);
        send_word(bsbp_pkg::REQ_PLOT, pack_word(x, y, color, $urandom_range(2047)));
    endtask

    task automatic read_byte(input int addr);
        send_word(bsbp_pkg::REQ_READ, pack_word($urandom_range(255), $urandom_range(63),
                                                $urandom_range(3), addr));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Register writes only happen once the core has returned every result.
    task automatic write_brush(input logic [bsbp_pkg::BRUSH_W-1:0] v);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_word();
        int x, y, dx, dy;
        if ($urandom_range(99) < 55) begin
            x = ($urandom_range(4) == 0) ? 254 * $urandom_range(1) + $urandom_range(1)
                                         : $urandom_range(255);
            y = ($urandom_range(4) == 0) ? 62 * $urandom_range(1) + $urandom_range(1)
                                         : $urandom_range(63);
            last_x = x;
            last_y = y;
            plot(x, y, $urandom_range(3));
        end else if ($urandom_range(99) < 70) begin
            // Read back around the latest stamp so that set bits show up.
            dx = $urandom_range(3) - 1;
            dy = $urandom_range(3) - 1;
            x = (last_x + dx) & 255;
            y = (last_y + dy) & 63;
            read_byte(y * ROW_BYTES + x / 8);
        end else begin
            read_byte($urandom_range(2047));
        end
    endtask

    initial begin
        sb = new;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = bsbp_pkg::REQ_PLOT;
        m_tready     = 1'b0;
        send_gap_pct = 0;
        stall_pct    = 0;
        last_x       = 0;
        last_y       = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: corners, clipping on every side, all colors and brush shapes.
        read_byte(0);
        read_byte(2047);
        plot(0, 0, 3);
        plot(255, 63, 1);
        read_byte(0);
        read_byte(2047);
        write_brush(3'd3);
        plot(0, 0, 2);
        plot(255, 63, 3);
        plot(128, 32, 0);
        read_byte(0);
        read_byte(2047);
        read_byte(32 * ROW_BYTES + 16);
        write_brush(3'd4);
        plot(0, 0, 1);
        plot(255, 63, 2);
        plot(254, 62, 3);
        read_byte(0);
        read_byte(31);
        read_byte(2047);
        read_byte(2015);
        write_brush(3'd2);
        plot(255, 63, 3);
        plot(7, 5, 1);
        read_byte(5 * ROW_BYTES);
        read_byte(2047);

        for (int ph = 0; ph < 8; ph++) begin
            write_brush(brush_plan[ph]);
            send_gap_pct = (ph % 4 == 1) ? 71 : (ph % 4 == 3) ? 36 : 0;
            stall_pct    = (ph % 4 == 2) ? 71 : (ph % 4 == 3) ? 36 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 2 && i == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                random_word();
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("Covered %0d plots (%0d pixels stamped) and %0d reads over brush sizes 0 to 7,",
                 sb.n_plots, sb.n_stamped, sb.n_reads);
        $display("with free-running, sender-gapped, receiver-stalled and mixed pacing.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("Timed out with %0d results outstanding.", sb.pending());
        $display("FAILURE");
        $finish;
    end

endmodule
